@@ design/bfsa_pkg.sv @@
// Shared types and constants for the best-fit segment allocator.
// Used by bfsa_cell and best_fit_segment_allocator; depends on nothing.
package bfsa_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int ADDR_BITS    = 20;
	localparam int LEN_W        = 21;
	localparam int TAG_W        = 16;
	localparam int LIFE_W       = 32;
	localparam int MODE_W       = 3;
	localparam int STAT_W       = 2;
	localparam int IN_W         = 104;
	localparam int OUT_W        = 64;

	localparam logic [LEN_W-1:0] MEM_CAP   = LEN_W'(1) << ADDR_BITS;
	localparam logic [LEN_W-1:0] MEM_RESET = LEN_W'(1024);

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FREE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COMPACT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_FIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_ID  = 2'd2;

	typedef struct packed {
		logic                 valid;
		logic [ADDR_BITS-1:0] base;
		logic [LEN_W-1:0]     len;
		logic [TAG_W-1:0]     tag;
		logic [LIFE_W-1:0]    life;
	} entry_t;

	localparam entry_t ENTRY_EMPTY = '0;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_INSERT,
		CELL_CLEAR
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t        cmd;
		logic [CNT_W-1:0] count;
		logic             keep;
		entry_t           wrap;
		entry_t           ins;
	} cell_ctl_t;

endpackage

@@ design/bfsa_cell.sv @@
// One cell of the segment row: holds one segment, passes it to its neighbors.
// Depends on bfsa_pkg.
module bfsa_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bfsa_pkg::IDX_W-1:0]  idx,
	input  bfsa_pkg::cell_ctl_t         ctl,
	input  bfsa_pkg::entry_t            next_e,
	input  bfsa_pkg::entry_t            prev_e,
	input  logic                        prev_lower,
	output bfsa_pkg::entry_t            e,
	output logic                        lower
);

	bfsa_pkg::entry_t e_q;
	logic             is_tail;
	logic             in_ring;

	// locate this cell within the live ring
	assign is_tail = ({1'b0, idx} + bfsa_pkg::CNT_W'(1)) == ctl.count;
	assign in_ring = {1'b0, idx} < ctl.count;
	assign lower   = e_q.valid && ({1'b0, e_q.base} < {1'b0, ctl.ins.base});
	assign e       = e_q;

	// advance, insert or drop the held segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= bfsa_pkg::ENTRY_EMPTY;
		end else begin
			case (ctl.cmd)
				bfsa_pkg::CELL_CLEAR: begin
					e_q.valid <= 1'b0;
				end
				bfsa_pkg::CELL_SHIFT: begin
					if (is_tail) begin
						e_q <= ctl.keep ? ctl.wrap : next_e;
					end else if (in_ring) begin
						e_q <= next_e;
					end
				end
				bfsa_pkg::CELL_INSERT: begin
					if (!lower) begin
						e_q <= prev_lower ? ctl.ins : prev_e;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ design/best_fit_segment_allocator.sv @@
// Best-fit segment allocator: a row of MAX_SEGMENTS cells kept in address order.
// Each request walks the ring of n live segments, one ring step per cycle; an allocate then
// checks the last gap and inserts; rejected requests and unknown modes skip the walk.
// One request at a time: a new request is taken only once the last result is in the output register.
// Reset: no segments, total_memory 1024, all words free.
// Depends on bfsa_pkg and bfsa_cell.
module best_fit_segment_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// mode[2:0] proc_id[18:3] proc_size[39:19] proc_time[71:40] elapsed[103:72]
	input  logic [bfsa_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0] address[21:2] free_memory[42:22] segment_count[49:43]
	// present[50] removed_count[57:51]
	output logic [bfsa_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bfsa_pkg::LEN_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FINAL, S_INSERT, S_DONE} state_t;

	state_t                            state_q;
	logic [bfsa_pkg::MODE_W-1:0]       mode_q;
	logic [bfsa_pkg::TAG_W-1:0]        id_q;
	logic [bfsa_pkg::LEN_W-1:0]        size_q;
	logic [bfsa_pkg::LIFE_W-1:0]       time_q;
	logic [bfsa_pkg::LIFE_W-1:0]       elapsed_q;
	logic [bfsa_pkg::CNT_W-1:0]        n_q;
	logic [bfsa_pkg::CNT_W-1:0]        rem_q;
	logic [bfsa_pkg::CNT_W-1:0]        removed_q;
	logic [bfsa_pkg::LEN_W-1:0]        free_q;
	logic [bfsa_pkg::LEN_W-1:0]        total_q;
	logic [bfsa_pkg::LEN_W-1:0]        pos_q;
	logic [bfsa_pkg::LEN_W-1:0]        best_len_q;
	logic [bfsa_pkg::ADDR_BITS-1:0]    best_addr_q;
	logic                              found_q;
	logic [bfsa_pkg::STAT_W-1:0]       status_q;
	logic [bfsa_pkg::ADDR_BITS-1:0]    addr_q;
	logic                              m_tvalid_q;
	logic [bfsa_pkg::OUT_W-1:0]        m_tdata_q;

	bfsa_pkg::entry_t                  cell_e [bfsa_pkg::MAX_SEGMENTS];
	logic                              cell_b [bfsa_pkg::MAX_SEGMENTS];
	bfsa_pkg::cell_ctl_t               ctl;
	bfsa_pkg::entry_t                  head;

	logic [bfsa_pkg::MODE_W-1:0]       in_mode;
	logic [bfsa_pkg::TAG_W-1:0]        in_id;
	logic [bfsa_pkg::LEN_W-1:0]        in_size;
	logic [bfsa_pkg::LIFE_W-1:0]       in_time;
	logic [bfsa_pkg::LIFE_W-1:0]       in_elapsed;
	logic                              in_reject;
	logic [bfsa_pkg::LEN_W-1:0]        cfg_clamped;
	logic [bfsa_pkg::LEN_W-1:0]        gap;
	logic [bfsa_pkg::LEN_W-1:0]        last_gap;
	logic                              gap_fits;
	logic                              last_fits;
	logic                              head_match;
	logic                              head_expired;
	logic                              head_drop;
	logic                              scanning;
	logic                              in_fire;
	logic                              cfg_fire;

	assign in_mode    = s_tdata[2:0];
	assign in_id      = s_tdata[18:3];
	assign in_size    = s_tdata[39:19];
	assign in_time    = s_tdata[71:40];
	assign in_elapsed = s_tdata[103:72];

	// a size write takes the idle slot ahead of a request
	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign cfg_clamped = (cfg_data == '0) ? bfsa_pkg::LEN_W'(1) :
		(cfg_data > bfsa_pkg::MEM_CAP) ? bfsa_pkg::MEM_CAP : cfg_data;

	// refuse an allocate up front when it cannot be placed
	assign in_reject = (in_mode == bfsa_pkg::MODE_ALLOC) && (in_size == '0 ||
		in_size > free_q || n_q == bfsa_pkg::CNT_W'(bfsa_pkg::MAX_SEGMENTS));

	// examine the segment at the head of the ring
	assign head         = cell_e[0];
	assign scanning     = (state_q == S_SCAN) && (rem_q != '0);
	assign gap          = {1'b0, head.base} - pos_q;
	assign gap_fits     = (gap >= size_q) && (!found_q || gap < best_len_q);
	assign last_gap     = total_q - pos_q;
	assign last_fits    = (pos_q < total_q) && (last_gap >= size_q) &&
		(!found_q || last_gap < best_len_q);
	assign head_match   = head.tag == id_q;
	assign head_expired = elapsed_q >= head.life;
	assign head_drop    = ((mode_q == bfsa_pkg::MODE_FREE) && !found_q && head_match) ||
		((mode_q == bfsa_pkg::MODE_TICK) && head_expired);

	// drive the cell row
	always_comb begin
		ctl       = '0;
		ctl.cmd   = bfsa_pkg::CELL_HOLD;
		ctl.count = n_q;
		ctl.keep  = !head_drop;
		ctl.wrap  = head;
		ctl.ins   = '{valid: 1'b1, base: best_addr_q, len: size_q, tag: id_q, life: time_q};
		if (mode_q == bfsa_pkg::MODE_TICK) begin
			ctl.wrap.life = head.life - elapsed_q;
		end
		if (mode_q == bfsa_pkg::MODE_COMPACT) begin
			ctl.wrap.base = pos_q[bfsa_pkg::ADDR_BITS-1:0];
		end
		if (cfg_fire) begin
			ctl.cmd = bfsa_pkg::CELL_CLEAR;
		end else if (scanning) begin
			ctl.cmd = bfsa_pkg::CELL_SHIFT;
		end else if (state_q == S_INSERT) begin
			ctl.cmd = bfsa_pkg::CELL_INSERT;
		end
	end

	for (genvar g = 0; g < bfsa_pkg::MAX_SEGMENTS; g++) begin : g_cell
		bfsa_pkg::entry_t nxt;
		bfsa_pkg::entry_t prv;
		logic             prv_b;
		if (g == bfsa_pkg::MAX_SEGMENTS - 1) begin : g_last
			assign nxt = bfsa_pkg::ENTRY_EMPTY;
		end else begin : g_mid
			assign nxt = cell_e[g+1];
		end
		if (g == 0) begin : g_first
			assign prv   = bfsa_pkg::ENTRY_EMPTY;
			assign prv_b = 1'b1;
		end else begin : g_rest
			assign prv   = cell_e[g-1];
			assign prv_b = cell_b[g-1];
		end
		bfsa_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (bfsa_pkg::IDX_W'(g)),
			.ctl        (ctl),
			.next_e     (nxt),
			.prev_e     (prv),
			.prev_lower (prv_b),
			.e          (cell_e[g]),
			.lower      (cell_b[g])
		);
	end

	// sequence one request through the ring and hold its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= '0;
			id_q        <= '0;
			size_q      <= '0;
			time_q      <= '0;
			elapsed_q   <= '0;
			n_q         <= '0;
			rem_q       <= '0;
			removed_q   <= '0;
			free_q      <= bfsa_pkg::MEM_RESET;
			total_q     <= bfsa_pkg::MEM_RESET;
			pos_q       <= '0;
			best_len_q  <= '0;
			best_addr_q <= '0;
			found_q     <= 1'b0;
			status_q    <= bfsa_pkg::ST_OK;
			addr_q      <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_fire) begin
				total_q <= cfg_clamped;
				free_q  <= cfg_clamped;
				n_q     <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						mode_q    <= in_mode;
						id_q      <= in_id;
						size_q    <= in_size;
						time_q    <= in_time;
						elapsed_q <= in_elapsed;
						rem_q     <= n_q;
						removed_q <= '0;
						pos_q     <= '0;
						found_q   <= 1'b0;
						addr_q    <= '0;
						status_q  <= in_reject ? bfsa_pkg::ST_NO_FIT : bfsa_pkg::ST_OK;
						state_q   <= (in_mode > bfsa_pkg::MODE_QUERY || in_reject) ?
							S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rem_q == '0) begin
						if (mode_q == bfsa_pkg::MODE_ALLOC) begin
							state_q <= S_FINAL;
						end else begin
							if (mode_q == bfsa_pkg::MODE_FREE && !found_q) begin
								status_q <= bfsa_pkg::ST_NO_ID;
							end
							state_q <= S_DONE;
						end
					end else begin
						rem_q <= rem_q - bfsa_pkg::CNT_W'(1);
						if (head_drop) begin
							n_q    <= n_q - bfsa_pkg::CNT_W'(1);
							free_q <= free_q + head.len;
						end
						case (mode_q)
							bfsa_pkg::MODE_ALLOC: begin
								if (gap_fits) begin
									found_q     <= 1'b1;
									best_len_q  <= gap;
									best_addr_q <= pos_q[bfsa_pkg::ADDR_BITS-1:0];
								end
								pos_q <= {1'b0, head.base} + head.len;
							end
							bfsa_pkg::MODE_FREE: begin
								if (head_drop) begin
									found_q <= 1'b1;
								end
							end
							bfsa_pkg::MODE_TICK: begin
								if (head_drop) begin
									removed_q <= removed_q + bfsa_pkg::CNT_W'(1);
								end
							end
							bfsa_pkg::MODE_COMPACT: begin
								pos_q <= pos_q + head.len;
							end
							bfsa_pkg::MODE_QUERY: begin
								if (head_match) begin
									found_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FINAL: begin
					if (last_fits) begin
						best_addr_q <= pos_q[bfsa_pkg::ADDR_BITS-1:0];
					end
					if (last_fits || found_q) begin
						state_q <= S_INSERT;
					end else begin
						status_q <= bfsa_pkg::ST_NO_FIT;
						state_q  <= S_DONE;
					end
				end
				S_INSERT: begin
					n_q     <= n_q + bfsa_pkg::CNT_W'(1);
					free_q  <= free_q - size_q;
					addr_q  <= best_addr_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'b0, removed_q,
							(mode_q == bfsa_pkg::MODE_QUERY) && found_q,
							n_q, free_q, addr_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for best_fit_segment_allocator: random and directed requests
// are checked against a behavioral allocator model kept in this file.
// Depends on bfsa_pkg and the allocator RTL.
module tb_top;

	localparam int STALL_LONG = 400;
	localparam longint CYCLE_LIMIT = 64'd4000000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [bfsa_pkg::IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [bfsa_pkg::OUT_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [bfsa_pkg::LEN_W-1:0] cfg_data;

	typedef struct packed {
		logic [6:0]  removed;
		logic        present;
		logic [6:0]  count;
		logic [20:0] free_mem;
		logic [19:0] address;
		logic [1:0]  status;
	} alloc_result_t;

	// allocator model state
	bit              seg_live [bfsa_pkg::MAX_SEGMENTS];
	longint unsigned seg_base [bfsa_pkg::MAX_SEGMENTS];
	longint unsigned seg_len  [bfsa_pkg::MAX_SEGMENTS];
	longint unsigned seg_tag  [bfsa_pkg::MAX_SEGMENTS];
	longint unsigned seg_life [bfsa_pkg::MAX_SEGMENTS];
	longint unsigned mem_total;
	longint unsigned mem_free;

	alloc_result_t expected_results[$];
	int errors = 0;
	int checked = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int sent = 0;
	longint cycles = 0;

	best_fit_segment_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// empty the model after a size write
	task automatic model_clear(input longint unsigned total);
		for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS; i++)
			seg_live[i] = 0;
		mem_total = total;
		mem_free = total;
	endtask

	function automatic int lowest_at_or_after(input longint unsigned pos);
		int best;
		best = -1;
		for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS; i++)
			if (seg_live[i] && seg_base[i] >= pos &&
				(best < 0 || seg_base[i] < seg_base[best]))
				best = i;
		return best;
	endfunction

	function automatic int lowest_with_tag(input longint unsigned tag);
		int best;
		best = -1;
		for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS; i++)
			if (seg_live[i] && seg_tag[i] == tag &&
				(best < 0 || seg_base[i] < seg_base[best]))
				best = i;
		return best;
	endfunction

	// work out the result of one request and advance the model
	task automatic predict_request(input logic [bfsa_pkg::IN_W-1:0] req);
		alloc_result_t r;
		logic [2:0] mode;
		longint unsigned tag, size, life, elapsed, pos, stop, gap, best_len, best_at;
		longint unsigned cursor, newpos;
		int slot, nx, cnt;
		bit found;
		mode = req[2:0];
		tag = 64'(req[18:3]);
		size = 64'(req[39:19]);
		life = 64'(req[71:40]);
		elapsed = 64'(req[103:72]);
		r = '0;
		case (mode)
			bfsa_pkg::MODE_ALLOC: begin
				slot = -1;
				for (int i = bfsa_pkg::MAX_SEGMENTS - 1; i >= 0; i--)
					if (!seg_live[i]) slot = i;
				if (size == 0 || size > mem_free || slot < 0) begin
					r.status = bfsa_pkg::ST_NO_FIT;
				end else begin
					found = 0;
					pos = 0;
					best_len = 0;
					best_at = 0;
					forever begin
						nx = lowest_at_or_after(pos);
						stop = (nx < 0) ? mem_total : seg_base[nx];
						if (stop > pos) begin
							gap = stop - pos;
							if (gap >= size && (!found || gap < best_len)) begin
								found = 1;
								best_len = gap;
								best_at = pos;
							end
						end
						if (nx < 0) break;
						pos = seg_base[nx] + seg_len[nx];
					end
					if (!found) begin
						r.status = bfsa_pkg::ST_NO_FIT;
					end else begin
						seg_live[slot] = 1;
						seg_base[slot] = best_at;
						seg_len[slot] = size;
						seg_tag[slot] = tag;
						seg_life[slot] = life;
						mem_free -= size;
						r.address = best_at[19:0];
					end
				end
			end
			bfsa_pkg::MODE_FREE: begin
				nx = lowest_with_tag(tag);
				if (nx < 0) begin
					r.status = bfsa_pkg::ST_NO_ID;
				end else begin
					seg_live[nx] = 0;
					mem_free += seg_len[nx];
				end
			end
			bfsa_pkg::MODE_TICK: begin
				for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS; i++) begin
					if (seg_live[i]) begin
						if (elapsed >= seg_life[i]) begin
							seg_live[i] = 0;
							mem_free += seg_len[i];
							r.removed++;
						end else begin
							seg_life[i] -= elapsed;
						end
					end
				end
			end
			bfsa_pkg::MODE_COMPACT: begin
				cursor = 0;
				newpos = 0;
				forever begin
					nx = lowest_at_or_after(cursor);
					if (nx < 0) break;
					cursor = seg_base[nx] + seg_len[nx];
					seg_base[nx] = newpos;
					newpos += seg_len[nx];
				end
			end
			bfsa_pkg::MODE_QUERY: r.present = (lowest_with_tag(tag) >= 0);
			default: ;
		endcase
		cnt = 0;
		for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS; i++)
			if (seg_live[i]) cnt++;
		r.count = cnt[6:0];
		r.free_mem = mem_free[20:0];
		expected_results.push_back(r);
	endtask

	// send one request and record its expected result at acceptance
	task automatic send_request(input logic [2:0] mode, input logic [15:0] tag,
			input logic [20:0] size, input logic [31:0] life, input logic [31:0] elapsed);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {elapsed, life, size, tag, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request({elapsed, life, size, tag, mode});
		sent++;
	endtask

	// drop the request line and wait until every result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// write the memory size while idle
	task automatic write_total(input logic [20:0] value);
		longint unsigned v;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		v = 64'(value);
		if (v == 0) v = 1;
		if (v > (64'd1 << bfsa_pkg::ADDR_BITS)) v = 64'd1 << bfsa_pkg::ADDR_BITS;
		model_clear(v);
	endtask

	// random request weighted toward allocate traffic that fits the memory
	task automatic random_request();
		int pick;
		logic [20:0] size;
		logic [31:0] life, el;
		pick = $urandom_range(99, 0);
		if ($urandom_range(9, 0) == 0) size = 21'($urandom);
		else size = 21'($urandom_range(32'(mem_total / 8 + 1), 1));
		life = ($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(40, 0);
		el = ($urandom_range(19, 0) == 0) ? $urandom : $urandom_range(8, 0);
		if (pick < 45)
			send_request(bfsa_pkg::MODE_ALLOC, 16'($urandom_range(15, 0)), size, life, el);
		else if (pick < 65)
			send_request(bfsa_pkg::MODE_FREE,
				16'(($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(15, 0)),
				size, life, el);
		else if (pick < 78)
			send_request(bfsa_pkg::MODE_TICK, 16'($urandom), size, life, el);
		else if (pick < 85)
			send_request(bfsa_pkg::MODE_COMPACT, 16'($urandom), size, life, el);
		else if (pick < 97)
			send_request(bfsa_pkg::MODE_QUERY, 16'($urandom_range(15, 0)), size, life, el);
		else
			send_request(3'($urandom_range(7, 5)), 16'($urandom), 21'($urandom),
				$urandom, $urandom);
	endtask

	task automatic test_directed();
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0000, 21'd0, 32'd5, 32'd0);
		send_request(bfsa_pkg::MODE_ALLOC, 16'hFFFF, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0001, 21'd100, 32'd10, 32'd0);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0002, 21'd50, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0003, 21'd100, 32'hFFFFFFFF, 32'd0);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0001, 21'd30, 32'd20, 32'd0);
		send_request(bfsa_pkg::MODE_FREE, 16'h0002, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0004, 21'd40, 32'd3, 32'd0);
		send_request(bfsa_pkg::MODE_FREE, 16'h0001, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_FREE, 16'h7777, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_QUERY, 16'h0001, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_QUERY, 16'hFFFF, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_COMPACT, 16'h0000, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_TICK, 16'h0000, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_TICK, 16'h0000, 21'd0, 32'd0, 32'd5);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0005, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0005, 21'd1024, 32'd1, 32'd0);
		send_request(3'd5, 16'hFFFF, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(3'd7, 16'h0000, 21'd0, 32'd0, 32'd0);
		send_request(bfsa_pkg::MODE_TICK, 16'hFFFF, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(bfsa_pkg::MODE_ALLOC, 16'h0006, 21'd900, 32'd1, 32'd0);
	endtask

	// fill the segment table to its limit with one-word segments
	task automatic test_full_table();
		write_total(21'd128);
		for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS + 2; i++)
			send_request(bfsa_pkg::MODE_ALLOC, 16'(i), 21'd1, $urandom_range(3, 0), 32'd0);
		send_request(bfsa_pkg::MODE_TICK, 16'd0, 21'd0, 32'd0, 32'd2);
		send_request(bfsa_pkg::MODE_COMPACT, 16'd0, 21'd0, 32'd0, 32'd0);
	endtask

	task automatic test_random(input int n);
		repeat (n) random_request();
	endtask

	// stall the receiver long enough to back up the input, drain, then send more requests
	task automatic test_backpressure();
		hold_off = STALL_LONG;
		repeat (10) random_request();
		wait_drained();
		repeat (20) random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		model_clear(64'd1024);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		write_total(21'd0);
		test_random(30);
		write_total(21'h1FFFFF);
		test_random(60);
		write_total(21'd1024);
		test_random(180);
		send_idle_pct = 49;
		test_random(180);
		write_total(21'd4096);
		send_idle_pct = 0;
		recv_stall_pct = 49;
		test_random(180);
		send_idle_pct = 29;
		recv_stall_pct = 29;
		test_random(150);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		wait_drained();
		$display("Covered %0d requests and %0d checked results over six size settings,", sent,
			checked);
		$display("including a full table, expiry, compaction, and idle and stall phases.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// receiver stalls, including one long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
		end
	end

	initial m_tready = 1'b0;

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[57:0];
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_results.pop_front();
				checked++;
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: st %0d/%0d addr %0d/%0d free %0d/%0d ",
							"cnt %0d/%0d pres %0d/%0d rem %0d/%0d (exp/act)"},
							want.status, got.status, want.address, got.address,
							want.free_mem, got.free_mem, want.count, got.count,
							want.present, got.present, want.removed, got.removed);
				end
			end
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
